// ===== rtl/dzve_pkg.sv =====
// ----------------------------------------------------------------------------
// dzve_pkg
// shared types, constants and byte helpers for the duration vint encoder
// ----------------------------------------------------------------------------
package dzve_pkg;

    localparam int MonWidth  = 32;
    localparam int DayWidth  = 32;
    localparam int NsWidth   = 64;
    localparam int InWidth   = MonWidth + DayWidth + NsWidth;
    localparam int LenBytes  = 4;

    localparam logic [7:0] ByteMask = 8'hff;

    // zigzag of a 32-bit value sign-extended to 64 bits fits in 33 bits
    localparam int ZSmallWidth = MonWidth + 1;

    // byte segments of one encoding
    typedef enum logic [1:0] {
        SEG_LEN  = 2'd0,
        SEG_MON  = 2'd1,
        SEG_DAY  = 2'd2,
        SEG_NANO = 2'd3
    } t_seg;

    // encoded item handed from the encode stage to the serialiser
    typedef struct packed {
        logic [ZSmallWidth-1:0] z_mon;
        logic [ZSmallWidth-1:0] z_day;
        logic [NsWidth-1:0]     z_ns;
        logic [3:0]             n_mon;
        logic [3:0]             n_day;
        logic [3:0]             n_ns;
        logic [4:0]             total;
        logic                   with_len;
    } t_enc;

    // smallest n in 1..8 with z < 2^(7n), else 9
    function automatic logic [3:0] vint_len(input logic [63:0] z);
        logic [3:0] n;
        n = 4'd9;
        for (int k = 8; k >= 1; k--) begin
            if ((z >> (7 * k)) == 64'd0) begin
                n = 4'(k);
            end
        end
        return n;
    endfunction

    // byte j (0 = first) of the n-byte vint of z, prefix bits included
    function automatic logic [7:0] vint_byte(input logic [63:0] z,
                                             input logic [3:0]  n,
                                             input logic [3:0]  j);
        logic [71:0] zx;
        logic [3:0]  k;
        logic [7:0]  b;
        zx = {8'h00, z};
        k  = n - 4'd1 - j;
        b  = zx[8 * k +: 8];
        if (j == 4'd0) begin
            b = b | (~(ByteMask >> (n - 4'd1)));
        end
        return b;
    endfunction

endpackage

// ===== rtl/dzve_encode.sv =====
// ----------------------------------------------------------------------------
// dzve_encode
// input register, zigzag mapping and vint sizing, result register
// ----------------------------------------------------------------------------
module dzve_encode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    output logic                         o_rdy,
    input  logic [dzve_pkg::MonWidth-1:0] i_months,
    input  logic [dzve_pkg::DayWidth-1:0] i_days,
    input  logic [dzve_pkg::NsWidth-1:0]  i_nanos,
    input  logic                         i_with_len,
    input  logic                         i_take,
    output dzve_pkg::t_enc               o_res,
    output logic                         o_res_vld
);

    logic                          r_in_vld;
    logic                          n_in_vld;
    logic [dzve_pkg::MonWidth-1:0] r_months;
    logic [dzve_pkg::DayWidth-1:0] r_days;
    logic [dzve_pkg::NsWidth-1:0]  r_nanos;
    logic                          r_with_len;

    logic                          r_res_vld;
    logic                          n_res_vld;
    dzve_pkg::t_enc                r_res;
    dzve_pkg::t_enc                n_res;

    logic                          res_load;
    logic                          in_acc;

    assign res_load = !r_res_vld || i_take;
    assign o_rdy    = !r_in_vld || res_load;
    assign in_acc   = i_vld && o_rdy;

    always_comb begin
        n_in_vld  = in_acc ? 1'b1 : (res_load ? 1'b0 : r_in_vld);
        n_res_vld = res_load ? r_in_vld : r_res_vld;

        // zigzag: (x << 1) ^ sign mask, high bits cancel for 32-bit values
        n_res.z_mon = {r_months, 1'b0} ^ {dzve_pkg::ZSmallWidth{r_months[31]}};
        n_res.z_day = {r_days, 1'b0} ^ {dzve_pkg::ZSmallWidth{r_days[31]}};
        n_res.z_ns  = {r_nanos[62:0], 1'b0} ^ {dzve_pkg::NsWidth{r_nanos[63]}};
        n_res.n_mon = dzve_pkg::vint_len({31'd0, n_res.z_mon});
        n_res.n_day = dzve_pkg::vint_len({31'd0, n_res.z_day});
        n_res.n_ns  = dzve_pkg::vint_len(n_res.z_ns);
        n_res.total = {1'b0, n_res.n_mon} + {1'b0, n_res.n_day} + {1'b0, n_res.n_ns};
        n_res.with_len = r_with_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_months   <= i_months;
            r_days     <= i_days;
            r_nanos    <= i_nanos;
            r_with_len <= i_with_len;
        end
        if (res_load) begin
            r_res <= n_res;
        end
    end

    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

`ifndef SYNTHESIS
    // 33-bit zigzag values never need more than five vint bytes
    a_mon_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> (r_res.n_mon >= 4'd1 && r_res.n_mon <= 4'd5))
        else $error("months vint length out of range");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> (r_res.total >= 5'd3 && r_res.total <= 5'd19))
        else $error("data byte count out of range");
`endif

endmodule

// ===== rtl/dzve_serial.sv =====
// ----------------------------------------------------------------------------
// dzve_serial
// walks optional length and vint segments, one byte per cycle unless stalled
// ----------------------------------------------------------------------------
module dzve_serial (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dzve_pkg::t_enc i_res,
    input  logic           i_res_vld,
    output logic           o_take,
    output logic           o_vld,
    input  logic           i_rdy,
    output logic [7:0]     o_byte,
    output logic           o_last
);

    dzve_pkg::t_seg r_seg;
    dzve_pkg::t_seg n_seg;
    dzve_pkg::t_seg cur_seg;
    logic [3:0]     r_idx;
    logic [3:0]     n_idx;
    logic [3:0]     seg_len;
    logic [7:0]     seg_byte;
    logic           seg_end;
    logic           gen;
    logic           gen_last;

    logic           r_out_vld;
    logic [7:0]     r_out_byte;
    logic           r_out_last;

    assign gen = i_res_vld && (!r_out_vld || i_rdy);

    always_comb begin
        cur_seg = r_seg;
        if (r_seg == dzve_pkg::SEG_LEN && !i_res.with_len) begin
            cur_seg = dzve_pkg::SEG_MON;
        end
        case (cur_seg)
            dzve_pkg::SEG_LEN: begin
                seg_len  = 4'(dzve_pkg::LenBytes);
                seg_byte = (r_idx == 4'(dzve_pkg::LenBytes - 1)) ? {3'd0, i_res.total} : 8'd0;
            end
            dzve_pkg::SEG_MON: begin
                seg_len  = i_res.n_mon;
                seg_byte = dzve_pkg::vint_byte({31'd0, i_res.z_mon}, i_res.n_mon, r_idx);
            end
            dzve_pkg::SEG_DAY: begin
                seg_len  = i_res.n_day;
                seg_byte = dzve_pkg::vint_byte({31'd0, i_res.z_day}, i_res.n_day, r_idx);
            end
            dzve_pkg::SEG_NANO: begin
                seg_len  = i_res.n_ns;
                seg_byte = dzve_pkg::vint_byte(i_res.z_ns, i_res.n_ns, r_idx);
            end
            default: begin
                seg_len  = 4'd1;
                seg_byte = 8'd0;
            end
        endcase

        seg_end  = (r_idx == seg_len - 4'd1);
        gen_last = seg_end && (cur_seg == dzve_pkg::SEG_NANO);

        n_seg = r_seg;
        n_idx = r_idx;
        if (gen) begin
            if (seg_end) begin
                n_idx = 4'd0;
                case (cur_seg)
                    dzve_pkg::SEG_LEN:  n_seg = dzve_pkg::SEG_MON;
                    dzve_pkg::SEG_MON:  n_seg = dzve_pkg::SEG_DAY;
                    dzve_pkg::SEG_DAY:  n_seg = dzve_pkg::SEG_NANO;
                    dzve_pkg::SEG_NANO: n_seg = dzve_pkg::SEG_LEN;
                    default:            n_seg = dzve_pkg::SEG_LEN;
                endcase
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
    end

    assign o_take = gen && gen_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg     <= dzve_pkg::SEG_LEN;
            r_idx     <= 4'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_seg <= n_seg;
            r_idx <= n_idx;
            if (gen) begin
                r_out_vld <= 1'b1;
            end else if (i_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen) begin
            r_out_byte <= seg_byte;
            r_out_last <= gen_last;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_byte = r_out_byte;
    assign o_last = r_out_last;

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_vld |-> (r_idx < seg_len))
        else $error("byte index beyond segment length");

    a_take_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_seg == dzve_pkg::SEG_LEN && r_idx == 4'd0))
        else $error("segment walk not restarted after final byte");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_vld |=> (r_seg == $past(r_seg) && r_idx == $past(r_idx)))
        else $error("segment walk moved without an item");
`endif

endmodule

// ===== rtl/duration_zigzag_vint_encoder.sv =====
// ----------------------------------------------------------------------------
// duration_zigzag_vint_encoder
// zigzag vint byte encoder for a months / days / nanoseconds duration
// ----------------------------------------------------------------------------
//  channel   direction  tdata                         tuser / tlast
//  s_axis    in         months, days, nanos (128 b)   tuser[0] = len_prefix
//  m_axis    out        out_byte (8 b)                tlast = last
//
//  one output byte per cycle unless m_axis stalls, set by the single output byte lane;
//  an item is 3 to 23 bytes long
//  items follow each other with their byte runs back to back when the next one waits
//  first byte passes the input, result and output registers before it is valid on m_axis
//  synchronous active-low reset empties every stage; no clearing pass
//  a stalled output holds its byte while the next item waits in the stages
// ----------------------------------------------------------------------------
module duration_zigzag_vint_encoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] months, [63:32] days, [127:64] nanos
    input  logic [127:0] s_axis_tdata,
    // [0] len_prefix
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast
);

    dzve_pkg::t_enc enc_res;
    logic           enc_vld;
    logic           enc_take;

    // input register, zigzag and length sizing, result register
    dzve_encode u_encode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (s_axis_tvalid),
        .o_rdy      (s_axis_tready),
        .i_months   (s_axis_tdata[31:0]),
        .i_days     (s_axis_tdata[63:32]),
        .i_nanos    (s_axis_tdata[127:64]),
        .i_with_len (s_axis_tuser[0]),
        .i_take     (enc_take),
        .o_res      (enc_res),
        .o_res_vld  (enc_vld)
    );

    // byte sequencer with registered output stage
    dzve_serial u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (enc_res),
        .i_res_vld (enc_vld),
        .o_take    (enc_take),
        .o_vld     (m_axis_tvalid),
        .i_rdy     (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule
